// ===== src/gbd_pkg.sv =====
// ----------------------------------------------------------------------------
// gbd_pkg: shared types and constants of the blur and downsample unit
// Command and status words between controller and datapath, register
// indexes, reset values and fixed field widths.
// ----------------------------------------------------------------------------
package gbd_pkg;

  localparam int IN_W       = 16;
  localparam int TAP_W      = 16;
  localparam int OUT_X_W    = 9;
  localparam int OUT_Y_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int WIDTH_REG_W  = 10;
  localparam int HEIGHT_REG_W = 13;

  localparam int MAX_OUT_HEIGHT = 4096;
  localparam int ROW_W          = 14;
  localparam int ROW_D3_W       = 13;
  localparam int STORE_ROWS     = 6;
  localparam int V_TAPS         = 7;

  localparam int RECIP_W   = 21;
  localparam logic [RECIP_W-1:0] AVG_RECIP = 21'd1864135;
  localparam int AVG_SHIFT = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_OUTER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_INNER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_CENTER = 3'd4;

  localparam logic [WIDTH_REG_W-1:0]  RST_OUT_WIDTH  = 10'd512;
  localparam logic [HEIGHT_REG_W-1:0] RST_OUT_HEIGHT = 13'd256;
  localparam logic [TAP_W-1:0]        RST_TAP_OUTER  = 16'd7871;
  localparam logic [TAP_W-1:0]        RST_TAP_INNER  = 16'd15329;
  localparam logic [TAP_W-1:0]        RST_TAP_CENTER = 16'd19209;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_FETCH, S_VMAC, S_WIN, S_HMAC, S_AVG, S_EMIT
  } gbd_state_t;

  typedef struct packed {
    logic in_valid;
    logic complete;
    logic fetch_done;
    logic mac_done;
    logic col_ge2;
    logic emit_cond;
    logic out_free;
  } gbd_sts_t;

  typedef struct packed {
    logic take;
    logic store_wr;
    logic fetch_run;
    logic mac_clr;
    logic mac_run;
    logic mac_horiz;
    logic win_upd;
    logic avg_run;
    logic emit;
  } gbd_cmd_t;

endpackage

// ===== src/gbd_pix_if.sv =====
// ----------------------------------------------------------------------------
// gbd_pix_if: input pixel channel
// Valid/ready channel carrying one supersampled RGB pixel per word.
// ----------------------------------------------------------------------------
interface gbd_pix_if;
  import gbd_pkg::*;

  logic            valid;
  logic            ready;
  logic [IN_W-1:0] red;
  logic [IN_W-1:0] green;
  logic [IN_W-1:0] blue;
  logic            frame_start;

  modport source (output valid, red, green, blue, frame_start, input ready);
  modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

// ===== src/gbd_res_if.sv =====
// ----------------------------------------------------------------------------
// gbd_res_if: output pixel channel
// Valid/ready channel carrying one averaged output pixel per word.
// ----------------------------------------------------------------------------
interface gbd_res_if;
  import gbd_pkg::*;

  logic               valid;
  logic               ready;
  logic [IN_W-1:0]    out_red;
  logic [IN_W-1:0]    out_green;
  logic [IN_W-1:0]    out_blue;
  logic [OUT_X_W-1:0] out_x;
  logic [OUT_Y_W-1:0] out_y;
  logic               frame_last;

  modport source (output valid, out_red, out_green, out_blue, out_x, out_y,
                  frame_last, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_x, out_y,
                  frame_last, output ready);
endinterface

// ===== src/gbd_ram.sv =====
// ----------------------------------------------------------------------------
// gbd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gbd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 9216
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/gbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbd_ctrl: sequencing state machine
// Stores each pixel; on a completing row runs row fetch, vertical filtering,
// window update and, once due, horizontal filtering, averaging and output.
// ----------------------------------------------------------------------------
module gbd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  gbd_pkg::gbd_sts_t sts,
  output gbd_pkg::gbd_cmd_t cmd
);
  import gbd_pkg::*;

  gbd_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (sts.in_valid) state_next = S_LOAD;
      end
      S_LOAD: begin
        if (sts.complete) begin
          state_next = S_FETCH;
        end else begin
          cmd.store_wr = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_FETCH: begin
        cmd.fetch_run = 1'b1;
        if (sts.fetch_done) begin
          // The word replaces the oldest stored row only once that row is read.
          cmd.store_wr = 1'b1;
          cmd.mac_clr  = 1'b1;
          state_next   = S_VMAC;
        end
      end
      S_VMAC: begin
        cmd.mac_run = 1'b1;
        if (sts.mac_done) state_next = S_WIN;
      end
      S_WIN: begin
        cmd.win_upd = 1'b1;
        if (sts.col_ge2) begin
          cmd.mac_clr = 1'b1;
          state_next  = S_HMAC;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_HMAC: begin
        cmd.mac_run   = 1'b1;
        cmd.mac_horiz = 1'b1;
        if (sts.mac_done) state_next = sts.emit_cond ? S_AVG : S_IDLE;
      end
      S_AVG: begin
        cmd.avg_run = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // An accepted word always goes on to the store write.
  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && sts.in_valid) |=> state == S_LOAD)
    else $error("accepted word did not reach the store write");

  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.take, cmd.fetch_run, cmd.mac_run, cmd.win_upd,
              cmd.avg_run, cmd.emit}))
    else $error("conflicting datapath commands");

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !sts.out_free) |=> state == S_EMIT)
    else $error("result left the emit state while the output was full");

endmodule

// ===== src/gbd_datapath.sv =====
// ----------------------------------------------------------------------------
// gbd_datapath: position counters, row store, filter MAC and averaging
// Holds the configuration, the six-row store, the vertical tap registers,
// the horizontal window, a three-lane multiply-accumulate unit shared by
// both filter passes and the output register.
// ----------------------------------------------------------------------------
module gbd_datapath #(
  parameter int MAX_OUT_WIDTH = 512,
  parameter int CHANNEL_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gbd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  gbd_pkg::gbd_cmd_t               cmd,
  output gbd_pkg::gbd_sts_t               sts,
  gbd_pix_if.sink                         pix,
  gbd_res_if.source                       res
);
  import gbd_pkg::*;

  localparam int CB    = CHANNEL_BITS;
  localparam int LL    = 3 * MAX_OUT_WIDTH;
  localparam int DEPTH = STORE_ROWS * LL;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(LL + 1);
  localparam int CD3W  = $clog2(MAX_OUT_WIDTH + 1);
  localparam int PW    = CB + TAP_W;
  localparam int ACCW  = PW + 3;
  localparam int BSW   = CB + 4;
  localparam int APW   = BSW + RECIP_W;
  localparam logic [CB-1:0] CHAN_MAX = {CB{1'b1}};

  typedef logic [2:0][CB-1:0] px_t;

  typedef struct packed {
    logic [CW-1:0]   col;
    logic [1:0]      m3;
    logic [CD3W-1:0] d3;
  } cpos_t;

  typedef struct packed {
    logic [ROW_W-1:0]    row;
    logic [2:0]          m6;
    logic [ROW_D3_W-1:0] d3;
  } rpos_t;

  function automatic rpos_t row_inc(input rpos_t p);
    rpos_t n;
    n.row = p.row + 1'b1;
    n.m6  = (p.m6 == 3'd5) ? 3'd0 : p.m6 + 3'd1;
    n.d3  = (p.m6 == 3'd2 || p.m6 == 3'd5) ? p.d3 + 1'b1 : p.d3;
    return n;
  endfunction

  function automatic cpos_t col_inc(input cpos_t p);
    cpos_t n;
    n.col = p.col + 1'b1;
    n.m3  = (p.m3 == 2'd2) ? 2'd0 : p.m3 + 2'd1;
    n.d3  = (p.m3 == 2'd2) ? p.d3 + 1'b1 : p.d3;
    return n;
  endfunction

  function automatic logic [CB-1:0] sat_in(input logic [IN_W-1:0] v);
    logic [CB-1:0] r;
    if (32'(v) > 32'(CHAN_MAX)) r = CHAN_MAX;
    else                         r = CB'(v);
    return r;
  endfunction

  function automatic logic [CB-1:0] rnd_sat(input logic [ACCW-1:0] s);
    logic [ACCW:0]    t;
    logic [ACCW-16:0] q;
    t = {1'b0, s} + (ACCW+1)'(32768);
    q = t[ACCW:16];
    return (q > (ACCW-15)'(CHAN_MAX)) ? CHAN_MAX : q[CB-1:0];
  endfunction

  // Configuration
  logic [WIDTH_REG_W-1:0]  cfg_w;
  logic [HEIGHT_REG_W-1:0] cfg_h;
  logic [TAP_W-1:0]        tap_o, tap_i, tap_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w <= RST_OUT_WIDTH;
      cfg_h <= RST_OUT_HEIGHT;
      tap_o <= RST_TAP_OUTER;
      tap_i <= RST_TAP_INNER;
      tap_c <= RST_TAP_CENTER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OUT_WIDTH:  cfg_w <= cfg_data[WIDTH_REG_W-1:0];
        CFG_OUT_HEIGHT: cfg_h <= cfg_data[HEIGHT_REG_W-1:0];
        CFG_TAP_OUTER:  tap_o <= cfg_data;
        CFG_TAP_INNER:  tap_i <= cfg_data;
        CFG_TAP_CENTER: tap_c <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [13:0]             w_ext;
  logic [CD3W-1:0]         eff_w;
  logic [HEIGHT_REG_W-1:0] eff_h;
  logic [CW-1:0]           w3;
  logic [ROW_W-1:0]        h3;

  always_comb begin
    w_ext = 14'(cfg_w);
    if (w_ext == 14'd0)                     eff_w = CD3W'(1);
    else if (w_ext > 14'(MAX_OUT_WIDTH))    eff_w = CD3W'(MAX_OUT_WIDTH);
    else                                    eff_w = CD3W'(w_ext);
    if (cfg_h == '0)                                 eff_h = HEIGHT_REG_W'(1);
    else if (cfg_h > HEIGHT_REG_W'(MAX_OUT_HEIGHT))  eff_h = HEIGHT_REG_W'(MAX_OUT_HEIGHT);
    else                                             eff_h = cfg_h;
    w3 = CW'(3 * 32'(eff_w));
    h3 = ROW_W'(3 * 32'(eff_h));
  end

  // Position tracking; column and row are kept with their remainders and
  // thirds so no divider is needed.
  cpos_t pcol, a_col, n_col;
  rpos_t prow, a_row, n_row;
  logic  accept;

  assign accept    = cmd.take && pix.valid;
  assign pix.ready = cmd.take;

  always_comb begin
    a_col = pcol;
    a_row = prow;
    if (pix.frame_start) begin
      a_col = '0;
      a_row = '0;
    end
    if (a_col.col >= w3) begin
      a_col = '0;
      a_row = row_inc(a_row);
    end
    if (a_row.row >= h3) a_row = '0;
    n_col = col_inc(a_col);
    n_row = a_row;
    if (n_col.col >= w3) begin
      n_col = '0;
      n_row = row_inc(a_row);
      if (n_row.row >= h3) n_row = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pcol <= '0;
      prow <= '0;
    end else if (accept) begin
      pcol <= n_col;
      prow <= n_row;
    end
  end

  // Current word
  px_t   ipx;
  cpos_t ic;
  rpos_t ir;

  always_ff @(posedge clk) begin
    if (accept) begin
      ipx <= {sat_in(pix.blue), sat_in(pix.green), sat_in(pix.red)};
      ic  <= a_col;
      ir  <= a_row;
    end
  end

  logic               i_last, i_lastrow;
  logic [2:0]         rm3_6;
  logic [1:0]         rm3;
  logic [2:0]         off;
  logic [1:0]         omax;
  logic [OUT_Y_W-1:0] oy;
  logic [OUT_X_W-1:0] ox;

  always_comb begin
    i_lastrow = (ir.row == h3 - 1'b1);
    i_last    = (ic.col == w3 - 1'b1);
    rm3_6     = (ir.m6 >= 3'd3) ? ir.m6 - 3'd3 : ir.m6;
    rm3       = rm3_6[1:0];
    off       = i_lastrow ? 3'd4 : 3'd6;
    omax      = i_last ? 2'd2 : 2'd0;
    oy        = i_lastrow ? OUT_Y_W'(eff_h - 1'b1) : OUT_Y_W'(ir.d3 - 1'b1);
    ox        = i_last ? OUT_X_W'(ic.d3) : OUT_X_W'(ic.d3 - 1'b1);
  end

  // Row store
  logic [2:0]    fcnt, f_idx, f_slot, f_rslot;
  logic [3:0]    f_sum;
  logic          f_neg;
  logic [AW-1:0] raddr, waddr;
  logic [3*CB-1:0] rdata;
  px_t           rd_px;
  px_t           vpix [V_TAPS];

  always_comb begin
    f_idx = fcnt - 3'd1;
    f_sum = 4'(ir.m6) + (i_lastrow ? 4'd2 : 4'd0) + 4'(fcnt);
    if (f_sum >= 4'd12)     f_slot = 3'(f_sum - 4'd12);
    else if (f_sum >= 4'd6) f_slot = 3'(f_sum - 4'd6);
    else                    f_slot = 3'(f_sum);
    // Rows above the frame are clamped to row 0.
    f_neg   = (15'(ir.row) + 15'(fcnt)) < 15'(off);
    f_rslot = f_neg ? 3'd0 : f_slot;
    raddr   = AW'(32'(f_rslot) * LL + 32'(ic.col));
    waddr   = AW'(32'(ir.m6) * LL + 32'(ic.col));
  end

  assign rd_px = rdata;

  gbd_ram #(.WIDTH(3 * CB), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (cmd.store_wr),
    .waddr (waddr),
    .wdata (ipx),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fcnt <= '0;
    end else if (cmd.take) begin
      fcnt <= '0;
    end else if (cmd.fetch_run && fcnt != 3'd7) begin
      fcnt <= fcnt + 3'd1;
    end
  end

  // Rows at or below the current one come from the word itself.
  always_ff @(posedge clk) begin
    if (cmd.fetch_run && fcnt != 3'd0) begin
      vpix[f_idx] <= (f_idx >= off) ? ipx : rd_px;
    end
  end

  // Shared MAC
  logic [2:0]          ik;
  logic [1:0]          it, io;
  logic                iss_live;
  logic                p_valid;
  logic [2:0]          p_k;
  logic [1:0]          p_t;
  logic [2:0][PW-1:0]  prod;
  logic [2:0][ACCW-1:0] acc, acc_sum;
  logic [2:0][CB-1:0]  fin;
  logic [TAP_W-1:0]    tap;
  logic [2:0]          vidx, hsum, hslot;
  px_t                 opnd;
  px_t                 vsum [3];
  px_t                 win [3][5];
  logic [2:0][BSW-1:0] bsum;
  logic [1:0]          omax_sel;

  always_comb begin
    unique case (ik) inside
      3'd2:       tap = tap_c;
      3'd1, 3'd3: tap = tap_i;
      default:    tap = tap_o;
    endcase
    vidx     = 3'(it) + ik;
    hsum     = 3'(io) + ik;
    hslot    = (hsum > 3'd4) ? 3'd4 : hsum;
    opnd     = cmd.mac_horiz ? win[it][hslot] : vpix[vidx];
    omax_sel = cmd.mac_horiz ? omax : 2'd0;
    for (int ch = 0; ch < 3; ch++) begin
      acc_sum[ch] = (p_k == 3'd0) ? ACCW'(prod[ch]) : acc[ch] + ACCW'(prod[ch]);
      fin[ch]     = rnd_sat(acc_sum[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_live <= 1'b0;
      p_valid  <= 1'b0;
      ik       <= '0;
      it       <= '0;
      io       <= '0;
    end else if (cmd.mac_clr) begin
      iss_live <= 1'b1;
      p_valid  <= 1'b0;
      ik       <= '0;
      it       <= '0;
      io       <= '0;
    end else if (cmd.mac_run) begin
      p_valid <= iss_live;
      if (iss_live) begin
        if (ik == 3'd4) begin
          ik <= '0;
          if (it == 2'd2) begin
            it <= '0;
            if (io == omax_sel) iss_live <= 1'b0;
            else                io <= io + 2'd1;
          end else begin
            it <= it + 2'd1;
          end
        end else begin
          ik <= ik + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_run && iss_live) begin
      p_k <= ik;
      p_t <= it;
      for (int ch = 0; ch < 3; ch++) begin
        prod[ch] <= tap * opnd[ch];
      end
    end
    if (cmd.mac_run && p_valid) begin
      acc <= acc_sum;
      if (p_k == 3'd4 && !cmd.mac_horiz) vsum[p_t] <= fin;
    end
  end

  // Horizontal window and block sums
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < 3; t++) begin
        for (int s = 0; s < 5; s++) win[t][s] <= '0;
      end
      bsum <= '0;
    end else begin
      if (cmd.win_upd) begin
        for (int t = 0; t < 3; t++) begin
          if (ic.col == '0) begin
            for (int s = 0; s < 5; s++) win[t][s] <= vsum[t];
          end else begin
            for (int s = 0; s < 4; s++) win[t][s] <= win[t][s+1];
            win[t][4] <= vsum[t];
          end
        end
        if (ic.col == '0) bsum <= '0;
      end else if (cmd.mac_run && cmd.mac_horiz && p_valid && p_k == 3'd4) begin
        for (int ch = 0; ch < 3; ch++) bsum[ch] <= bsum[ch] + BSW'(fin[ch]);
      end else if (cmd.emit) begin
        bsum <= '0;
      end
    end
  end

  // Averaging by the reciprocal of nine, rounded, then saturated.
  logic [2:0][APW-1:0]  aprod;
  logic [2:0][APW:0]    arnd;
  logic [2:0][APW-AVG_SHIFT:0] aq;
  logic [2:0][CB-1:0]   avg;

  always_ff @(posedge clk) begin
    if (cmd.avg_run) begin
      for (int ch = 0; ch < 3; ch++) aprod[ch] <= bsum[ch] * AVG_RECIP;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      arnd[ch] = {1'b0, aprod[ch]} + (APW+1)'(1 << (AVG_SHIFT - 1));
      aq[ch]   = arnd[ch][APW:AVG_SHIFT];
      avg[ch]  = (aq[ch] > (APW-AVG_SHIFT+1)'(CHAN_MAX)) ? CHAN_MAX : aq[ch][CB-1:0];
    end
  end

  // Output register
  logic o_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (cmd.emit) begin
      o_valid <= 1'b1;
    end else if (res.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res.out_red    <= IN_W'(avg[0]);
      res.out_green  <= IN_W'(avg[1]);
      res.out_blue   <= IN_W'(avg[2]);
      res.out_x      <= ox;
      res.out_y      <= oy;
      res.frame_last <= i_last && i_lastrow;
    end
  end

  assign res.valid = o_valid;

  always_comb begin
    sts.in_valid   = pix.valid;
    sts.complete   = i_lastrow || (ir.row >= ROW_W'(4) && rm3 == 2'd1);
    sts.fetch_done = (fcnt == 3'd7);
    sts.mac_done   = !iss_live && !p_valid;
    sts.col_ge2    = (ic.col >= CW'(2));
    sts.emit_cond  = i_last || (ic.m3 == 2'd1 && ic.col >= CW'(4));
    sts.out_free   = !o_valid || res.ready;
  end

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> res.valid)
    else $error("emitted word not presented");

  a_mac_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.mac_clr |=> (iss_live && !p_valid))
    else $error("MAC did not restart cleanly");

  a_fetch_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.fetch_run && fcnt == 3'd7) |=> !cmd.fetch_run)
    else $error("fetch ran past the last tap");

endmodule

// ===== src/gaussian_blur_downsample_3x_unit.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_downsample_3x_unit: 5-tap blur and 3x3 box downsample
// Blurs supersampled RGB pixels vertically and horizontally and averages
// each 3x3 block into one output pixel.
//
//   channel   dir   handshake       word
//   pix_in    in    valid/ready     red, green, blue, frame_start
//   res_out   out   valid/ready     out_red/green/blue, out_x, out_y, frame_last
//   cfg_*     in    cfg_we          cfg_index, cfg_data
//
// A pixel on a row that completes no output row is only stored. A pixel on
// a completing row goes through the seven row-store reads and the single
// three-lane MAC unit shared by both passes, which filters one horizontal
// column, or three at the right edge. Reset is synchronous; the row store
// is not cleared. A waiting result sits in the output register while the
// next pixel is taken; only a second result stalls the sequencer.
// ----------------------------------------------------------------------------
module gaussian_blur_downsample_3x_unit #(
  parameter int MAX_OUT_WIDTH = 512,
  parameter int CHANNEL_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  gbd_pix_if.sink                        pix_in,
  gbd_res_if.source                      res_out,
  input  logic                           cfg_we,
  input  logic [gbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gbd_pkg::*;

  gbd_cmd_t cmd;
  gbd_sts_t sts;

  gbd_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  gbd_datapath #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .CHANNEL_BITS  (CHANNEL_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .pix       (pix_in),
    .res       (res_out)
  );

endmodule

// ===== tb/gaussian_blur_downsample_3x_unit_tb.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_downsample_3x_unit_tb: self-checking bench for the blur unit
// Streams supersampled frames of many sizes and kernels through the unit,
// predicts every averaged output pixel with a bit-true software copy of the
// line stores and filters, and compares each output word with the prediction.
// ----------------------------------------------------------------------------
module gaussian_blur_downsample_3x_unit_tb;
  import gbd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_LEN   = 3 * 512;
  localparam int CYCLE_STOP = 3000000;

  typedef logic [2:0][15:0] rgb_t;

  typedef struct packed {
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic [OUT_X_W-1:0] x;
    logic [OUT_Y_W-1:0] y;
    logic               last;
  } blur_px_t;

  class blur_scoreboard;
    rgb_t              line_mem [6*LINE_LEN];
    rgb_t              hwin [3][5];
    longint unsigned   acc [3];
    int unsigned       col_pos = 0;
    int unsigned       row_pos = 0;
    int unsigned       width_reg = 512;
    int unsigned       height_reg = 256;
    int unsigned       t_outer = 7871;
    int unsigned       t_inner = 15329;
    int unsigned       t_center = 19209;
    blur_px_t          pending [$];
    int                errors = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
      case (idx)
        CFG_OUT_WIDTH:  width_reg  = val & 10'h3ff;
        CFG_OUT_HEIGHT: height_reg = val & 13'h1fff;
        CFG_TAP_OUTER:  t_outer    = val & 16'hffff;
        CFG_TAP_INNER:  t_inner    = val & 16'hffff;
        CFG_TAP_CENTER: t_center   = val & 16'hffff;
        default: ;
      endcase
    endfunction

    function int unsigned fir5(int unsigned v [5]);
      longint unsigned s;
      s = 0;
      for (int k = 0; k < 5; k++)
        s += longint'(k == 2 ? t_center : (k == 1 || k == 3) ? t_inner : t_outer) * v[k];
      s = (s + 32768) >> 16;
      return (s > 65535) ? 65535 : int'(s);
    endfunction

    function int unsigned fetch(int q, int unsigned c, int unsigned r, rgb_t px, int ch);
      if (q < 0) q = 0;
      if (q >= int'(r)) return px[ch];
      return line_mem[(q % 6) * LINE_LEN + c][ch];
    endfunction

    function void note_pixel(rgb_t px, bit fs);
      int unsigned w3, h3, c, r, oy, first, lastc, slot;
      bit          complete, last;
      rgb_t        vsum [3];
      int unsigned v [5];
      blur_px_t    word;
      longint unsigned a;
      w3 = 3 * ((width_reg == 0) ? 1 : (width_reg > 512) ? 512 : width_reg);
      h3 = 3 * ((height_reg == 0) ? 1 : (height_reg > 4096) ? 4096 : height_reg);
      if (fs) begin
        col_pos = 0;
        row_pos = 0;
      end
      if (col_pos >= w3) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= h3) row_pos = 0;
      c = col_pos;
      r = row_pos;
      complete = 0;
      oy = 0;
      if (r == h3 - 1) begin
        complete = 1;
        oy = h3 / 3 - 1;
      end else if (r >= 4 && (r - 4) % 3 == 0) begin
        complete = 1;
        oy = (r - 4) / 3;
      end
      if (complete) begin
        last = (c == w3 - 1);
        for (int t = 0; t < 3; t++)
          for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 5; k++) v[k] = fetch(int'(3 * oy) + t - 2 + k, c, r, px, ch);
            vsum[t][ch] = fir5(v);
          end
        for (int t = 0; t < 3; t++) begin
          if (c == 0) begin
            for (int k = 0; k < 5; k++) hwin[t][k] = vsum[t];
          end else begin
            for (int k = 0; k < 4; k++) hwin[t][k] = hwin[t][k+1];
            hwin[t][4] = vsum[t];
          end
        end
        if (c == 0) acc = '{0, 0, 0};
        if (c >= 2) begin
          first = c - 2;
          lastc = last ? c : c - 2;
          for (int unsigned cc = first; cc <= lastc; cc++) begin
            for (int t = 0; t < 3; t++)
              for (int ch = 0; ch < 3; ch++) begin
                for (int k = 0; k < 5; k++) begin
                  slot = cc + 2 + k - c;
                  if (slot > 4) slot = 4;
                  v[k] = hwin[t][slot][ch];
                end
                acc[ch] += fir5(v);
              end
            if (cc % 3 == 2) begin
              for (int ch = 0; ch < 3; ch++) begin
                a = (acc[ch] * 64'd1864135 + 64'd8388608) >> 24;
                if (a > 65535) a = 65535;
                if (ch == 0) word.red = a[15:0];
                else if (ch == 1) word.green = a[15:0];
                else word.blue = a[15:0];
              end
              word.x = cc / 3;
              word.y = oy;
              word.last = last && (r == h3 - 1);
              pending = {pending, word};
              acc = '{0, 0, 0};
            end
          end
        end
      end
      line_mem[(r % 6) * LINE_LEN + c] = px;
      col_pos = c + 1;
      if (col_pos >= w3) begin
        col_pos = 0;
        row_pos = r + 1;
        if (row_pos >= h3) row_pos = 0;
      end
    endfunction

    function void check_word(blur_px_t got);
      blur_px_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output word %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("output mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  gbd_pix_if             pix ();
  gbd_res_if             res ();
  blur_scoreboard        sb;
  int                    cycles = 0;
  int                    sent = 0;
  bit                    quiet = 0;
  int                    stall_left = 0;
  bit                    need_fs = 1;

  gaussian_blur_downsample_3x_unit dut (
    .clk(clk), .rst(rst), .pix_in(pix), .res_out(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 9);
    if (quiet || sel < 6) return 0;
    if (sel < 9) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [15:0] pick_chan();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      res.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      res.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // Accepted words are taken at the rising edge, inputs before outputs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_STOP) begin
      $display("tb: failure");
      $finish;
    end
    if (!rst) begin
      if (pix.valid && pix.ready) sb.note_pixel({pix.blue, pix.green, pix.red}, pix.frame_start);
      if (res.valid && res.ready)
        sb.check_word({res.out_red, res.out_green, res.out_blue, res.out_x, res.out_y,
                       res.frame_last});
    end
  end

  task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b, bit fs);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix.red <= r;
    pix.green <= g;
    pix.blue <= b;
    pix.frame_start <= fs;
    pix.valid <= 1'b1;
    do @(posedge clk); while (!pix.ready);
    @(negedge clk);
    sent++;
  endtask

  // Lets the unit run dry, then allows for a pixel that is still in flight.
  task automatic drain();
    pix.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  // The write enable stays high across a run of writes and is dropped by
  // the caller.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(int w, int h, int t_o, int t_i, int t_c);
    drain();
    write_reg(CFG_OUT_WIDTH, 16'(w));
    write_reg(CFG_OUT_HEIGHT, 16'(h));
    write_reg(CFG_TAP_OUTER, 16'(t_o));
    write_reg(CFG_TAP_INNER, 16'(t_i));
    write_reg(CFG_TAP_CENTER, 16'(t_c));
    cfg_we <= 1'b0;
    need_fs = 1;
  endtask

  // Sends a frame of the given output size, or only its first npix pixels.
  task automatic send_frame(int w, int h, int npix);
    int total;
    total = 9 * w * h;
    if (npix > total) npix = total;
    for (int i = 0; i < npix; i++)
      send_pixel(pick_chan(), pick_chan(), pick_chan(), (i == 0) && need_fs);
    need_fs = (npix < total);
  endtask

  initial begin
    int w, h, nframes, cut;
    sb = new;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_OUT_WIDTH;
    cfg_data = '0;
    pix.valid = 1'b0;
    pix.red = '0;
    pix.green = '0;
    pix.blue = '0;
    pix.frame_start = 1'b0;
    res.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: single-pixel outputs with extreme values and kernels.
    configure(1, 1, RST_TAP_OUTER, RST_TAP_INNER, RST_TAP_CENTER);
    for (int i = 0; i < 9; i++)
      send_pixel(i[0] ? 16'hffff : 16'h0000, i[1] ? 16'hffff : 16'h0000, 16'hffff, i == 0);
    configure(0, 0, 65535, 65535, 65535);
    for (int i = 0; i < 9; i++) send_pixel(16'hffff, 16'hffff, 16'h8000, i == 0);
    configure(1, 1, 0, 0, 0);
    for (int i = 0; i < 9; i++) send_pixel(16'hffff, 16'h1234, 16'h0001, 1'b0);

    // Widest row, with width saturated from the largest register value; only
    // its first pixels, then restarted under a new setting.
    configure(1023, 1, $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535));
    send_frame(512, 1, 60);
    // Tallest frame, only its top rows, then restarted under a new setting.
    configure(1, 8191, RST_TAP_OUTER, RST_TAP_INNER, RST_TAP_CENTER);
    send_frame(1, 4096, 60);

    while (sent < 800) begin
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      if ($urandom_range(0, 3) == 0)
        configure(w, h, RST_TAP_OUTER, RST_TAP_INNER, RST_TAP_CENTER);
      else
        configure(w, h, $urandom_range(0, 24000), $urandom_range(0, 24000),
                  $urandom_range(0, 65535));
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      nframes = $urandom_range(1, 3);
      for (int f = 0; f < nframes; f++) begin
        quiet = ($urandom_range(0, 3) == 0);
        // Most frames are whole; some are cut short and restarted.
        cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 9 * w * h) : 9 * w * h;
        if (!need_fs && $urandom_range(0, 1) == 0) need_fs = 1;
        send_frame(w, h, cut);
      end
      quiet = 0;
    end

    pix.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
src/gbd_pkg.sv
src/gbd_pix_if.sv
src/gbd_res_if.sv
src/gbd_ram.sv
src/gbd_ctrl.sv
src/gbd_datapath.sv
src/gaussian_blur_downsample_3x_unit.sv
tb/gaussian_blur_downsample_3x_unit_tb.sv
